// File: rtl/bptc_pkg.sv
`timescale 1ns / 1ps

package bptc_pkg;

  // Field and coefficient widths
  localparam int D_W      = 24;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = 18;
  localparam int CFG_IDX_W = 3;

  // First-order shifts
  localparam int TREF_SHIFT  = 8;   // C5 * 2^8
  localparam int TEMP_SHIFT  = 23;  // dT*C6 / 2^23
  localparam int OFF_C_SHIFT = 16;  // C2 * 2^16
  localparam int OFF_SHIFT   = 7;   // dT*C4 / 2^7
  localparam int SENS_C_SHIFT = 15; // C1 * 2^15
  localparam int SENS_SHIFT  = 8;   // dT*C3 / 2^8

  // Pressure shifts
  localparam int P_SHIFT_HI = 21;
  localparam int P_SHIFT_LO = 15;

  // Internal widths
  localparam int DT_W    = D_W + 2;               // D2 - C5*2^8, signed
  localparam int MP_W    = DT_W + COEF_W + 1;     // dT * coefficient, signed
  localparam int TEMP_W  = MP_W - TEMP_SHIFT;     // TEMP and its offsets, signed
  localparam int OFF_W   = 40;                    // OFF, SENS and their nets, signed
  localparam int SQ_W    = 2 * TEMP_W;            // squares of temperature offsets
  localparam int SPLIT_W = OFF_W / 2;             // low slice of SENS for the product
  localparam int PL_W    = D_W + SPLIT_W;         // D1 * low slice, unsigned
  localparam int PH_W    = D_W + 1 + OFF_W - SPLIT_W; // D1 * high slice, signed
  localparam int PROD_W  = PH_W + SPLIT_W;        // full D1 * SENS
  localparam int Q_W     = PROD_W - P_SHIFT_HI;   // product / 2^21
  localparam int R_W     = Q_W + 1;               // minus OFF
  localparam int PR_W    = R_W - P_SHIFT_LO;      // pressure before clamping

  // Temperature thresholds, as offsets from TEMP - 2000
  localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = TEMP_W'(3500); // 2000 + 1500

  // Output clamp limits
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -TEMP_W'(131072);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = TEMP_W'(131071);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS     = 3'd0,
    CFG_OFF      = 3'd1,
    CFG_TCS      = 3'd2,
    CFG_TCO      = 3'd3,
    CFG_TREF     = 3'd4,
    CFG_TEMPSENS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } coeff_t;

  // First-order result
  typedef struct packed {
    logic [D_W-1:0]    d1;
    logic [TEMP_W-1:0] tdiff;  // TEMP - 2000
    logic [TEMP_W-1:0] tcold;  // TEMP + 1500
    logic [TEMP_W-1:0] temp;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  sens;
  } fo_t;

  // Corrected offset and sensitivity
  typedef struct packed {
    logic [D_W-1:0]    d1;
    logic [TEMP_W-1:0] temp;
    logic [OFF_W-1:0]  off_net;
    logic [OFF_W-1:0]  sens_net;
  } so_t;

endpackage

// File: rtl/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps
// Channel  Ports                                              Transfer
// input    in_valid, in_ready, in_raw_pressure,               in_valid & in_ready
//          in_raw_temperature
// output   out_valid, out_ready, out_temperature_centi,       out_valid & out_ready
//          out_pressure_pa
// config   cfg_we, cfg_index, cfg_wdata                       cfg_we
//
// One reading pair per cycle unless a stalled output has filled the pipe; each result
// passes through the nine-stage pipeline before out_valid rises. The D1 x SENS product is
// split into two partial products over two stages.
// Reset clears every stage valid bit and all six coefficients to zero.
// Each stage advances when empty or when its successor advances, so bubbles close
// up and a stalled output still lets new readings enter until the pipe is full.

module baro_temp_pressure_compensation import bptc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [D_W-1:0]          in_raw_pressure,
  input  logic [D_W-1:0]          in_raw_temperature,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_temperature_centi,
  output logic [OUT_W-1:0]        out_pressure_pa,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]       cfg_wdata
);

  coeff_t coef;
  fo_t    fo_data;
  so_t    so_data;
  logic   fo_valid, fo_ready;
  logic   so_valid, so_ready;

  bptc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  bptc_first_order u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_d1    (in_raw_pressure),
    .up_d2    (in_raw_temperature),
    .dn_valid (fo_valid),
    .dn_ready (fo_ready),
    .dn_data  (fo_data)
  );

  bptc_second_order u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fo_valid),
    .up_ready (fo_ready),
    .up_data  (fo_data),
    .dn_valid (so_valid),
    .dn_ready (so_ready),
    .dn_data  (so_data)
  );

  bptc_pressure u_press (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (so_valid),
    .up_ready    (so_ready),
    .up_data     (so_data),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .dn_temp     (out_temperature_centi),
    .dn_pressure (out_pressure_pa)
  );

endmodule

// File: rtl/bptc_cfg_regs.sv
`timescale 1ns / 1ps

module bptc_cfg_regs import bptc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output coeff_t               coef
);

  coeff_t coef_r;

  // Coefficient writes; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SENS:     coef_r.sens     <= cfg_wdata;
        CFG_OFF:      coef_r.off      <= cfg_wdata;
        CFG_TCS:      coef_r.tcs      <= cfg_wdata;
        CFG_TCO:      coef_r.tco      <= cfg_wdata;
        CFG_TREF:     coef_r.tref     <= cfg_wdata;
        CFG_TEMPSENS: coef_r.tempsens <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign coef = coef_r;

endmodule

// File: rtl/bptc_first_order.sv
`timescale 1ns / 1ps

module bptc_first_order import bptc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  coeff_t         coef,
  input  logic           up_valid,
  output logic           up_ready,
  input  logic [D_W-1:0] up_d1,
  input  logic [D_W-1:0] up_d2,
  output logic           dn_valid,
  input  logic           dn_ready,
  output fo_t            dn_data
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [D_W-1:0]         d1_s1_r, d1_s2_r;
  logic signed [DT_W-1:0] dt_r, dt_nxt;
  logic signed [MP_W-1:0] m6_r, m4_r, m3_r;
  logic signed [MP_W-1:0] m6_nxt, m4_nxt, m3_nxt;
  logic [TEMP_W-1:0]      tdiff;
  fo_t                    fo_r, fo_nxt;

  // Stage handshake: a stage moves when empty or when the next one moves
  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_data  = fo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: dT = D2 - C5*2^8
  assign dt_nxt = $signed({2'b00, up_d2}) - $signed({2'b00, coef.tref, {TREF_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= up_d1;
    end
  end

  // Stage 2: the three dT products
  assign m6_nxt = dt_r * $signed({1'b0, coef.tempsens});
  assign m4_nxt = dt_r * $signed({1'b0, coef.tco});
  assign m3_nxt = dt_r * $signed({1'b0, coef.tcs});

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      m6_r    <= m6_nxt;
      m4_r    <= m4_nxt;
      m3_r    <= m3_nxt;
      d1_s2_r <= d1_s1_r;
    end
  end

  // Stage 3: TEMP, OFF, SENS; upper slices are floor shifts
  assign tdiff = m6_r[MP_W-1:TEMP_SHIFT];

  always_comb begin
    fo_nxt       = '0;
    fo_nxt.d1    = d1_s2_r;
    fo_nxt.tdiff = tdiff;
    fo_nxt.temp  = tdiff + TEMP_REF;
    fo_nxt.tcold = tdiff + TEMP_COLD;
    fo_nxt.off   = {{(OFF_W-COEF_W-OFF_C_SHIFT){1'b0}}, coef.off, {OFF_C_SHIFT{1'b0}}}
                 + {{(OFF_W-MP_W+OFF_SHIFT){m4_r[MP_W-1]}}, m4_r[MP_W-1:OFF_SHIFT]};
    fo_nxt.sens  = {{(OFF_W-COEF_W-SENS_C_SHIFT){1'b0}}, coef.sens, {SENS_C_SHIFT{1'b0}}}
                 + {{(OFF_W-MP_W+SENS_SHIFT){m3_r[MP_W-1]}}, m3_r[MP_W-1:SENS_SHIFT]};
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      fo_r <= fo_nxt;
    end
  end

  // A held item stays put under backpressure
  a_fo_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !dn_ready |=> v3_r && $stable(fo_r))
    else $error("first-order result changed while stalled");

endmodule

// File: rtl/bptc_second_order.sv
`timescale 1ns / 1ps

module bptc_second_order import bptc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  fo_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output so_t  dn_data
);

  logic v4_r, v5_r, v6_r;
  logic rdy4, rdy5, rdy6;

  // Stage 4 registers and the stage 5 copies of the pass-through fields
  logic [D_W-1:0]    d1_s4_r, d1_s5_r;
  logic [TEMP_W-1:0] temp_s4_r, temp_s5_r;
  logic [OFF_W-1:0]  off_s4_r, sens_s4_r, off_s5_r, sens_s5_r;
  logic [SQ_W-1:0]   sq_d_r, sq_e_r, sq_d_nxt, sq_e_nxt;
  logic              below_ref_r, below_cold_r;

  // Stage 5 correction registers and their combinational terms
  logic [SQ_W-1:0]   off2_r, sens2_r, off2_nxt, sens2_nxt;
  logic [SQ_W-1:0]   d5, e7, e11;

  so_t so_r, so_nxt;

  assign rdy6     = !v6_r || dn_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign up_ready = rdy4;
  assign dn_valid = v6_r;
  assign dn_data  = so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= up_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // Stage 4: squares of (TEMP-2000) and (TEMP+1500)
  assign sq_d_nxt = $signed(up_data.tdiff) * $signed(up_data.tdiff);
  assign sq_e_nxt = $signed(up_data.tcold) * $signed(up_data.tcold);

  always_ff @(posedge clk) begin
    if (rdy4 && up_valid) begin
      sq_d_r       <= sq_d_nxt;
      sq_e_r       <= sq_e_nxt;
      below_ref_r  <= up_data.tdiff[TEMP_W-1];
      below_cold_r <= up_data.tcold[TEMP_W-1];
      d1_s4_r      <= up_data.d1;
      temp_s4_r    <= up_data.temp;
      off_s4_r     <= up_data.off;
      sens_s4_r    <= up_data.sens;
    end
  end

  // Stage 5: correction terms by shift, add and subtract
  assign d5  = (sq_d_r << 2) + sq_d_r;
  assign e7  = (sq_e_r << 3) - sq_e_r;
  assign e11 = (sq_e_r << 3) + (sq_e_r << 1) + sq_e_r;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (below_ref_r) begin
      off2_nxt  = d5 >> 1;
      sens2_nxt = d5 >> 2;
      if (below_cold_r) begin
        off2_nxt  = (d5 >> 1) + e7;
        sens2_nxt = (d5 >> 2) + (e11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      off2_r    <= off2_nxt;
      sens2_r   <= sens2_nxt;
      d1_s5_r   <= d1_s4_r;
      temp_s5_r <= temp_s4_r;
      off_s5_r  <= off_s4_r;
      sens_s5_r <= sens_s4_r;
    end
  end

  // Stage 6: net offset and sensitivity
  always_comb begin
    so_nxt          = '0;
    so_nxt.d1       = d1_s5_r;
    so_nxt.temp     = temp_s5_r;
    so_nxt.off_net  = off_s5_r - off2_r;
    so_nxt.sens_net = sens_s5_r - sens2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy6 && v5_r) begin
      so_r <= so_nxt;
    end
  end

  // Warm readings carry no correction
  a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rdy5 && v4_r && !below_ref_r) |-> off2_r == '0 && sens2_r == '0)
    else $error("correction applied above reference temperature");

  // Offset correction always dominates sensitivity correction
  a_off_ge_sens: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> off2_r >= sens2_r)
    else $error("offset correction below sensitivity correction");

endmodule

// File: rtl/bptc_pressure.sv
`timescale 1ns / 1ps

module bptc_pressure import bptc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  so_t                     up_data,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [OUT_W-1:0] dn_temp,
  output logic [OUT_W-1:0]        dn_pressure
);

  logic v7_r, v8_r, v9_r;
  logic rdy7, rdy8, rdy9;

  logic [PL_W-1:0]         pl_r, pl_nxt;
  logic signed [PH_W-1:0]  ph_r, ph_nxt;
  logic [OFF_W-1:0]        off_s7_r, off_s8_r;
  logic [OUT_W-1:0]        tsat_s7_r, tsat_s8_r, tsat_nxt;
  logic signed [PROD_W-1:0] prod;
  logic [Q_W-1:0]          q_r;
  logic signed [R_W-1:0]   diff;
  logic [PR_W-1:0]         pr;
  logic [OUT_W-1:0]        temp_r, press_r, press_nxt;

  assign rdy9     = !v9_r || dn_ready;
  assign rdy8     = !v8_r || rdy9;
  assign rdy7     = !v7_r || rdy8;
  assign up_ready = rdy7;
  assign dn_valid = v9_r;
  assign dn_temp  = $signed(temp_r);
  assign dn_pressure = press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      if (rdy7) v7_r <= up_valid;
      if (rdy8) v8_r <= v7_r;
      if (rdy9) v9_r <= v8_r;
    end
  end

  // Stage 7: D1 * SENS as two partial products; clamp temperature
  assign pl_nxt = up_data.d1 * up_data.sens_net[SPLIT_W-1:0];
  assign ph_nxt = $signed({1'b0, up_data.d1}) * $signed(up_data.sens_net[OFF_W-1:SPLIT_W]);

  always_comb begin
    if ($signed(up_data.temp) < TEMP_MIN) begin
      tsat_nxt = TEMP_MIN[OUT_W-1:0];
    end else if ($signed(up_data.temp) > TEMP_MAX) begin
      tsat_nxt = TEMP_MAX[OUT_W-1:0];
    end else begin
      tsat_nxt = up_data.temp[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && up_valid) begin
      pl_r      <= pl_nxt;
      ph_r      <= ph_nxt;
      off_s7_r  <= up_data.off_net;
      tsat_s7_r <= tsat_nxt;
    end
  end

  // Stage 8: merge partials, floor divide by 2^21
  assign prod = $signed({ph_r, {SPLIT_W{1'b0}}})
              + $signed({{(PROD_W-PL_W){1'b0}}, pl_r});

  always_ff @(posedge clk) begin
    if (rdy8 && v7_r) begin
      q_r       <= prod[PROD_W-1:P_SHIFT_HI];
      off_s8_r  <= off_s7_r;
      tsat_s8_r <= tsat_s7_r;
    end
  end

  // Stage 9: subtract OFF, floor divide by 2^15, clamp to output range
  assign diff = $signed({q_r[Q_W-1], q_r})
              - $signed({{(R_W-OFF_W){off_s8_r[OFF_W-1]}}, off_s8_r});
  assign pr   = diff[R_W-1:P_SHIFT_LO];

  always_comb begin
    if (pr[PR_W-1]) begin
      press_nxt = '0;
    end else if (|pr[PR_W-2:OUT_W]) begin
      press_nxt = '1;
    end else begin
      press_nxt = pr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy9 && v8_r) begin
      press_r <= press_nxt;
      temp_r  <= tsat_s8_r;
    end
  end

  // Mid-pipe item holds while the output stage is blocked
  a_q_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v8_r && !rdy9 |=> v8_r && $stable(q_r) && $stable(off_s8_r))
    else $error("pressure stage lost data under stall");

endmodule

// File: tb/sv/baro_temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_tb;
  import bptc_pkg::*;

  localparam int NUM_COEFFS = 6;
  localparam int PIPE_LATENCY = 9;
  localparam int MAX_PRINTED = 40;
  localparam int BURST_LEN = 32;

  // Temperature thresholds in 0.01 degC and output saturation limits
  localparam longint TEMP_NOMINAL = 2000;
  localparam longint TEMP_FROST = -1500;
  localparam longint TEMP_OUT_MIN = -131072;
  localparam longint TEMP_OUT_MAX = 131071;
  localparam longint PRES_OUT_MAX = 262143;

  localparam logic [D_W-1:0] RAW_MAX = '1;
  localparam logic [COEF_W-1:0] COEF_MAX = '1;
  // Reading close to typical room conditions
  localparam logic [D_W-1:0] RAW_P_TYPICAL = 24'd9085466;
  // dT offset that puts TEMP just at the frost threshold (one less puts it just below)
  // for the typical temperature sensitivity coefficient
  localparam longint DT_FROST_EDGE = -1037020;

  typedef struct packed {
    logic signed [OUT_W-1:0] temp_centi;
    logic [OUT_W-1:0]        pressure_pa;
  } comp_result_t;

  // Holds the coefficient copy and the compensated readings still owed by the block
  class comp_scoreboard;
    logic [COEF_W-1:0] coeff [NUM_COEFFS];
    comp_result_t      owed_q [$];
    int                errors;

    function new();
      foreach (coeff[i]) coeff[i] = '0;
      errors = 0;
    endfunction

    function void set_coeff(int idx, logic [COEF_W-1:0] val);
      if (idx < NUM_COEFFS) coeff[idx] = val;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    // Second-order compensation, exact 64-bit math, >>> floors signed values
    function comp_result_t compensate(logic [D_W-1:0] d1, logic [D_W-1:0] d2);
      longint dt, temp, off, sens, off2, sens2, sq, p;
      comp_result_t r;
      dt = longint'(d2) - (longint'(coeff[CFG_TREF]) <<< TREF_SHIFT);
      temp = TEMP_NOMINAL + ((dt * longint'(coeff[CFG_TEMPSENS])) >>> TEMP_SHIFT);
      off = (longint'(coeff[CFG_OFF]) <<< OFF_C_SHIFT)
            + ((dt * longint'(coeff[CFG_TCO])) >>> OFF_SHIFT);
      sens = (longint'(coeff[CFG_SENS]) <<< SENS_C_SHIFT)
             + ((dt * longint'(coeff[CFG_TCS])) >>> SENS_SHIFT);
      off2 = 0;
      sens2 = 0;
      // cold correction, with an extra term in frost
      if (temp < TEMP_NOMINAL) begin
        sq = (temp - TEMP_NOMINAL) * (temp - TEMP_NOMINAL);
        off2 = (5 * sq) >>> 1;
        sens2 = (5 * sq) >>> 2;
        if (temp < TEMP_FROST) begin
          sq = (temp - TEMP_FROST) * (temp - TEMP_FROST);
          off2 += 7 * sq;
          sens2 += (11 * sq) >>> 1;
        end
      end
      p = (((longint'(d1) * (sens - sens2)) >>> P_SHIFT_HI) - (off - off2)) >>> P_SHIFT_LO;
      // only the outputs saturate
      if (temp < TEMP_OUT_MIN) temp = TEMP_OUT_MIN;
      if (temp > TEMP_OUT_MAX) temp = TEMP_OUT_MAX;
      if (p < 0) p = 0;
      if (p > PRES_OUT_MAX) p = PRES_OUT_MAX;
      r.temp_centi = temp[OUT_W-1:0];
      r.pressure_pa = p[OUT_W-1:0];
      return r;
    endfunction

    function void note_reading(logic [D_W-1:0] d1, logic [D_W-1:0] d2);
      owed_q.push_back(compensate(d1, d2));
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when something goes badly wrong
      if (errors <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic signed [OUT_W-1:0] t, logic [OUT_W-1:0] p);
      comp_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result transfer with no reading pending (temp %0d, p %0d)", t, p));
      end else begin
        want = owed_q.pop_front();
        if (t !== want.temp_centi)
          report($sformatf("temperature_centi got %0d, want %0d", t, want.temp_centi));
        if (p !== want.pressure_pa)
          report($sformatf("pressure_pa got %0d, want %0d", p, want.pressure_pa));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [D_W-1:0]          in_raw_pressure;
  logic [D_W-1:0]          in_raw_temperature;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] out_temperature_centi;
  logic [OUT_W-1:0]        out_pressure_pa;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [COEF_W-1:0]       cfg_wdata;

  comp_scoreboard sb = new();
  bit sender_burst;
  bit receiver_burst;

  baro_temp_pressure_compensation dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pa       (out_pressure_pa),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Transfer monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_reading(in_raw_pressure, in_raw_temperature);
    if (rst_n && out_valid && out_ready) sb.check_result(out_temperature_centi, out_pressure_pa);
  end

  // Result side: random stall before each transfer, with stall-free stretches
  initial begin
    int stall;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    receiver_burst = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % BURST_LEN == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      stall = receiver_burst ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Hang guard
  initial begin
    #2000000;
    $display("baro_temp_pressure_compensation_tb failed");
    $finish;
  end

  function logic [COEF_W-1:0] typical_coeff(int idx);
    case (idx)
      CFG_SENS:     return 16'd40127;
      CFG_OFF:      return 16'd36924;
      CFG_TCS:      return 16'd23317;
      CFG_TCO:      return 16'd23282;
      CFG_TREF:     return 16'd33464;
      default:      return 16'd28312;
    endcase
  endfunction

  task send_reading(logic [D_W-1:0] d1, logic [D_W-1:0] d2);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_raw_pressure = d1;
    in_raw_temperature = d2;
    do @(posedge clk); while (!in_ready);
  endtask

  task close_stream();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task write_reg(int idx, logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx[CFG_IDX_W-1:0];
    cfg_wdata = val;
    sb.set_coeff(idx, val);
  endtask

  // Program all six coefficients; a junk write to a spare index lands before one of them
  task load_coeffs(logic [COEF_W-1:0] vals [NUM_COEFFS]);
    int spare_at;
    spare_at = $urandom_range(0, NUM_COEFFS - 1);
    for (int i = 0; i < NUM_COEFFS; i++) begin
      if (i == spare_at)
        write_reg(NUM_COEFFS + $urandom_range(0, 1), COEF_W'($urandom_range(0, 65535)));
      write_reg(i, vals[i]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drain every owed result before touching the registers
  task wait_idle();
    close_stream();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Random readings: mostly full range, some near the reference temperature,
  // some at the field extremes
  task run_random(int count);
    logic [D_W-1:0] d1, d2;
    longint near;
    int mode;
    for (int k = 0; k < count; k++) begin
      if (k % BURST_LEN == 0) sender_burst = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      d1 = D_W'($urandom_range(0, 24'hFFFFFF));
      d2 = D_W'($urandom_range(0, 24'hFFFFFF));
      if (mode >= 6 && mode <= 8) begin
        near = (longint'(sb.coeff[CFG_TREF]) <<< TREF_SHIFT)
               + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        if (near < 0) near = 0;
        if (near > longint'(RAW_MAX)) near = longint'(RAW_MAX);
        d2 = near[D_W-1:0];
      end else if (mode == 9) begin
        if ($urandom_range(0, 1)) d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
        if ($urandom_range(0, 1)) d2 = $urandom_range(0, 1) ? RAW_MAX : '0;
      end
      send_reading(d1, d2);
    end
    sender_burst = 1'b0;
  endtask

  initial begin
    logic [COEF_W-1:0] vals [NUM_COEFFS];
    logic [D_W-1:0] tref_raw;
    in_valid = 1'b0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sender_burst = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Coefficients left at reset: all zero
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    run_random(100);
    wait_idle();

    // Typical calibration: threshold edges and field extremes
    foreach (vals[i]) vals[i] = typical_coeff(i);
    load_coeffs(vals);
    tref_raw = D_W'(longint'(vals[CFG_TREF]) <<< TREF_SHIFT);
    send_reading(RAW_P_TYPICAL, tref_raw);
    send_reading(RAW_P_TYPICAL, D_W'(tref_raw - 1));
    send_reading(RAW_P_TYPICAL, D_W'(tref_raw + 1));
    send_reading(RAW_P_TYPICAL, D_W'(longint'(tref_raw) + DT_FROST_EDGE));
    send_reading(RAW_P_TYPICAL, D_W'(longint'(tref_raw) + DT_FROST_EDGE - 1));
    send_reading('0, D_W'(longint'(tref_raw) + DT_FROST_EDGE - 1));
    send_reading(RAW_MAX, D_W'(longint'(tref_raw) + DT_FROST_EDGE - 1));
    send_reading(RAW_MAX, tref_raw);
    send_reading(RAW_P_TYPICAL, '0);
    send_reading(RAW_P_TYPICAL, RAW_MAX);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, '0);
    run_random(500);
    wait_idle();

    // Every coefficient at full scale
    foreach (vals[i]) vals[i] = COEF_MAX;
    load_coeffs(vals);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, D_W'(longint'(COEF_MAX) <<< TREF_SHIFT));
    run_random(250);
    wait_idle();

    // Mixed settings: each coefficient zero, full scale, typical or random
    repeat (4) begin
      foreach (vals[i]) begin
        case ($urandom_range(0, 3))
          0:       vals[i] = '0;
          1:       vals[i] = COEF_MAX;
          2:       vals[i] = typical_coeff(i);
          default: vals[i] = COEF_W'($urandom_range(0, 65535));
        endcase
      end
      load_coeffs(vals);
      run_random(225);
      wait_idle();
    end

    // Allow for any stray result behind the last one
    repeat (PIPE_LATENCY * 3) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("baro_temp_pressure_compensation_tb passed");
    end else begin
      $display("baro_temp_pressure_compensation_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bptc_pkg.sv
rtl/bptc_cfg_regs.sv
rtl/bptc_first_order.sv
rtl/bptc_second_order.sv
rtl/bptc_pressure.sv
rtl/baro_temp_pressure_compensation.sv
tb/sv/baro_temp_pressure_compensation_tb.sv
